[rtl/fmo_pkg.sv]
`timescale 1ns / 1ps
package fmo_pkg;

  localparam int DEF_PHASE_BITS = 32;
  localparam int DEF_EXP_TABLE_DEPTH = 256;

  localparam int EXP_LIMIT = 12288;
  localparam int SYNC_HI = 2048;
  localparam int SYNC_LO = 204;
  localparam int FULL_SCALE = 5120;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 30;
  localparam logic [29:0] STEP_SCALE_RESET = 30'd23409861;

  localparam logic [CFG_IDX_W-1:0] REG_PITCH_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_FM_AMOUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_FM_AMOUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOFT_SYNC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRI_OFFSET = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SQR_OFFSET = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SAW_OFFSET = 3'd7;

  typedef struct packed {
    logic load;
    logic exp_mul1;
    logic exp_mul2;
    logic exp_sum;
    logic lin_mul1;
    logic lin_mul2;
    logic table_read;
    logic interp;
    logic ratio;
    logic scale_hi;
    logic scale_lo;
    logic phase_upd;
    logic wave;
  } fmo_cmd_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n, r, b;
    n = n_in;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > n) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] exp_entry(input int i, input int depth);
    logic [63:0] roots [21];
    logic [63:0] x, v;
    roots[0] = 64'd1 << 31;
    for (int k = 1; k <= 20; k++) roots[k] = isqrt64(roots[k-1] << 30);
    x = (64'(i) << 20) / 64'(depth);
    v = 64'd1 << 30;
    if (x[20]) begin
      v = 64'd1 << 31;
      x = 64'd0;
    end
    for (int j = 19; j >= 0; j--) begin
      if (x[j]) v = (v * roots[20-j]) >> 30;
    end
    return v[31:0];
  endfunction

endpackage

[rtl/fmo_ctrl.sv]
`timescale 1ns / 1ps
module fmo_ctrl
  import fmo_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_fire_i,
  input  logic     out_busy_i,
  output logic     in_ready_o,
  output logic     out_load_o,
  output fmo_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EM1  = 4'd1;
  localparam logic [3:0] S_EM2  = 4'd2;
  localparam logic [3:0] S_ESUM = 4'd3;
  localparam logic [3:0] S_LM1  = 4'd4;
  localparam logic [3:0] S_LM2  = 4'd5;
  localparam logic [3:0] S_TAB  = 4'd6;
  localparam logic [3:0] S_INT  = 4'd7;
  localparam logic [3:0] S_RAT  = 4'd8;
  localparam logic [3:0] S_SHI  = 4'd9;
  localparam logic [3:0] S_SLO  = 4'd10;
  localparam logic [3:0] S_PH   = 4'd11;
  localparam logic [3:0] S_WAV  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    out_load_o = 1'b0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_fire_i;
        if (in_fire_i) state_d = S_EM1;
      end
      S_EM1: begin cmd_o.exp_mul1 = 1'b1; state_d = S_EM2; end
      S_EM2: begin cmd_o.exp_mul2 = 1'b1; state_d = S_ESUM; end
      S_ESUM: begin cmd_o.exp_sum = 1'b1; state_d = S_LM1; end
      S_LM1: begin cmd_o.lin_mul1 = 1'b1; state_d = S_LM2; end
      S_LM2: begin cmd_o.lin_mul2 = 1'b1; state_d = S_TAB; end
      S_TAB: begin cmd_o.table_read = 1'b1; state_d = S_INT; end
      S_INT: begin cmd_o.interp = 1'b1; state_d = S_RAT; end
      S_RAT: begin cmd_o.ratio = 1'b1; state_d = S_SHI; end
      S_SHI: begin cmd_o.scale_hi = 1'b1; state_d = S_SLO; end
      S_SLO: begin cmd_o.scale_lo = 1'b1; state_d = S_PH; end
      S_PH: begin cmd_o.phase_upd = 1'b1; state_d = S_WAV; end
      S_WAV: begin cmd_o.wave = 1'b1; state_d = S_OUT; end
      S_OUT: begin
        if (!out_busy_i) begin
          out_load_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

[rtl/fmo_datapath.sv]
`timescale 1ns / 1ps
module fmo_datapath
  import fmo_pkg::*;
#(
  parameter int PHASE_BITS = DEF_PHASE_BITS,
  parameter int EXP_TABLE_DEPTH = DEF_EXP_TABLE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fmo_cmd_t            cmd_i,
  input  logic [149:0]        in_data_i,
  input  logic signed [14:0]  pitch_offset_i,
  input  logic signed [15:0]  exp_fm_amount_i,
  input  logic signed [15:0]  lin_fm_amount_i,
  input  logic                soft_sync_i,
  input  logic [29:0]         phase_step_scale_i,
  input  logic signed [12:0]  tri_phase_offset_i,
  input  logic signed [12:0]  sqr_phase_offset_i,
  input  logic signed [12:0]  saw_phase_offset_i,
  output logic signed [13:0]  tri_level_o,
  output logic signed [13:0]  sqr_level_o,
  output logic signed [13:0]  saw_level_o
);

  localparam int TAB_AW = $clog2(EXP_TABLE_DEPTH);
  localparam int MAGW = PHASE_BITS + 32;
  localparam int FRAC_W = $clog2(EXP_TABLE_DEPTH*1024+1);

  logic [31:0] exp_tab [EXP_TABLE_DEPTH+1];
  always_comb begin
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) exp_tab[i] = exp_entry(i, EXP_TABLE_DEPTH);
  end

  logic signed [14:0] pcv_q, efm_q, ed_q, lfm_q, ld_q, sl_q, mixm_q, trim_q, sqrm_q, sawm_q;
  logic signed [29:0] prod1_q;
  logic signed [45:0] prod2_q;
  logic signed [14:0] e_q;
  logic [FRAC_W-1:0] frac_q;
  logic signed [4:0] ip_q;
  logic [31:0] t0_q, t1_q, m_q;
  logic signed [46:0] linq_q;
  logic signed [47:0] ratio_q;
  logic [47:0] mag_q;
  logic [MAGW-1:0] inc_q;
  logic [PHASE_BITS-1:0] phase_q;
  logic run_back_q, sync_high_q, edge_q;
  logic signed [13:0] tri_q, sqr_q, saw_q;

  logic signed [14:0] sx [10];
  always_comb begin
    for (int i = 0; i < 10; i++) sx[i] = in_data_i[i*15 +: 15];
  end

  function automatic logic signed [14:0] clamp_depth(input logic signed [14:0] v);
    if (v > 15'sd5120) return 15'sd5120;
    if (v < -15'sd5120) return -15'sd5120;
    return v;
  endfunction

  // Floor division by 5 for operands of up to about 21 bits.
  function automatic logic signed [45:0] floor_div5(input logic signed [45:0] v);
    logic signed [45:0] qt;
    qt = (v * 46'sd52429) >>> 18;
    if (v - qt * 46'sd5 < 0) qt = qt - 46'sd1;
    else if (v - qt * 46'sd5 >= 46'sd5) qt = qt + 46'sd1;
    return qt;
  endfunction

  // floor division by 5120*16384 = 5 * 2^24
  logic signed [45:0] q24;
  logic signed [45:0] ediv;
  logic signed [17:0] esum;
  always_comb begin
    q24 = prod2_q >>> 24;
    ediv = floor_div5(q24);
    esum = 18'(pcv_q) + 18'(pitch_offset_i) + 18'(ediv);
  end

  // floor division by 80 = 5 * 2^4
  // Since 2^20 leaves a remainder of one modulo 5, the high part contributes
  // (2^20-1)/5 per unit exactly and is also added into the small remainder.
  logic signed [45:0] q4, q4_hi, q4_lo, ldiv;
  always_comb begin
    q4 = prod2_q >>> 4;
    q4_hi = q4 >>> 20;
    q4_lo = 46'(q4[19:0]);
    ldiv = q4_hi * 46'sd209715 + floor_div5(q4_hi + q4_lo);
  end

  logic [14:0] u_w;
  always_comb u_w = 15'(e_q + 15'sd12288);

  logic signed [43:0] interp_w;
  logic [31:0] m_w;
  logic [47:0] pw_w;
  always_comb begin
    interp_w = ($signed({1'b0, t1_q}) - $signed({1'b0, t0_q})) *
               $signed({1'b0, frac_q[9:0]});
    m_w = 32'($signed({1'b0, t0_q}) + (interp_w >>> 10));
    if (ip_q >= 0) pw_w = 48'(m_q) << ip_q;
    else pw_w = 48'(m_q) >> (-ip_q);
  end

  logic [MAGW-1:0] lim_w, sat_w, shifted_w;
  logic phase_neg_w;
  always_comb begin
    lim_w = (MAGW'(1) << (PHASE_BITS - 1)) - MAGW'(1);
    if (PHASE_BITS >= 32) shifted_w = inc_q << (PHASE_BITS - 32);
    else shifted_w = inc_q >> (32 - PHASE_BITS);
    sat_w = (shifted_w > lim_w) ? lim_w : shifted_w;
    phase_neg_w = ratio_q[47] != run_back_q;
  end

  logic [PHASE_BITS-1:0] tp, qp, sp, half, quarter, tph;
  logic [PHASE_BITS+13:0] tprod, sprod;
  always_comb begin
    half = PHASE_BITS'(1) << (PHASE_BITS - 1);
    quarter = PHASE_BITS'(1) << (PHASE_BITS - 2);
    tp = phase_q + (PHASE_BITS'(18'(mixm_q) + 18'(trim_q) + 18'(tri_phase_offset_i))
         << (PHASE_BITS - 12)) - quarter;
    qp = phase_q + (PHASE_BITS'(18'(mixm_q) + 18'(sqrm_q) + 18'(sqr_phase_offset_i))
         << (PHASE_BITS - 12));
    sp = phase_q + (PHASE_BITS'(18'(mixm_q) + 18'(sawm_q) + 18'(saw_phase_offset_i))
         << (PHASE_BITS - 12));
    tph = (tp < half) ? tp : tp - half;
    tprod = (PHASE_BITS+14)'(tph) * (PHASE_BITS+14)'(10240);
    sprod = (PHASE_BITS+14)'(sp) * (PHASE_BITS+14)'(10240);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pcv_q <= sx[0]; efm_q <= sx[1]; ed_q <= clamp_depth(sx[2]);
      lfm_q <= sx[3]; ld_q <= clamp_depth(sx[4]); sl_q <= sx[5];
      mixm_q <= sx[6]; trim_q <= sx[7]; sqrm_q <= sx[8]; sawm_q <= sx[9];
    end
    if (cmd_i.exp_mul1) prod1_q <= efm_q * ed_q;
    if (cmd_i.exp_mul2) prod2_q <= 46'(prod1_q) * 46'(exp_fm_amount_i);
    if (cmd_i.exp_sum) begin
      if (esum > 18'sd12288) e_q <= 15'sd12288;
      else if (esum < -18'sd12288) e_q <= -15'sd12288;
      else e_q <= 15'(esum);
    end
    if (cmd_i.lin_mul1) begin
      prod1_q <= lfm_q * ld_q;
      ip_q <= 5'(u_w >> 10) - 5'sd12;
      frac_q <= FRAC_W'(u_w[9:0]) * FRAC_W'(EXP_TABLE_DEPTH);
    end
    if (cmd_i.lin_mul2) prod2_q <= 46'(prod1_q) * 46'(lin_fm_amount_i);
    if (cmd_i.table_read) begin
      linq_q <= 47'(ldiv);
      t0_q <= exp_tab[TAB_AW'(frac_q >> 10)];
      t1_q <= exp_tab[(TAB_AW+1)'(frac_q >> 10) + (TAB_AW+1)'(1)];
      frac_q <= FRAC_W'(frac_q[9:0]);
    end
    if (cmd_i.interp) m_q <= m_w;
    if (cmd_i.ratio) begin
      ratio_q <= $signed({1'b0, pw_w[46:0]}) + 48'(linq_q);
    end
    if (cmd_i.scale_hi) begin
      mag_q <= ratio_q[47] ? 48'(-ratio_q) : 48'(ratio_q);
    end
    if (cmd_i.scale_lo) begin
      inc_q <= MAGW'(MAGW'(mag_q[47:30]) * MAGW'(phase_step_scale_i)) +
               MAGW'((60'(mag_q[29:0]) * 60'(phase_step_scale_i)) >> 30);
    end
    if (cmd_i.wave) begin
      tri_q <= (tp < half) ? 14'(15'sd5120 - 15'(tprod >> (PHASE_BITS - 1)))
                           : 14'(15'(tprod >> (PHASE_BITS - 1)) - 15'sd5120);
      sqr_q <= (qp < half) ? 14'sd5120 : -14'sd5120;
      saw_q <= 14'(15'(sprod >> PHASE_BITS) - 15'sd5120);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      run_back_q <= 1'b0;
      sync_high_q <= 1'b0;
      edge_q <= 1'b0;
    end else begin
      if (cmd_i.exp_mul1) begin
        edge_q <= !sync_high_q && (sl_q >= 15'sd2048);
        if (sync_high_q) begin
          if (sl_q <= 15'sd204) sync_high_q <= 1'b0;
        end else if (sl_q >= 15'sd2048) begin
          sync_high_q <= 1'b1;
          if (soft_sync_i) run_back_q <= ~run_back_q;
        end
      end
      if (cmd_i.phase_upd) begin
        if (edge_q && !soft_sync_i) phase_q <= '0;
        else if (phase_neg_w) phase_q <= phase_q - PHASE_BITS'(sat_w);
        else phase_q <= phase_q + PHASE_BITS'(sat_w);
      end
    end
  end

  assign tri_level_o = tri_q;
  assign sqr_level_o = sqr_q;
  assign saw_level_o = saw_q;

endmodule

[rtl/fm_sync_multiwave_oscillator_unit.sv]
`timescale 1ns / 1ps
// FM oscillator with sync and triangle, square and saw outputs.
// The slave channel s_axis carries one sample tick per item: ten 15-bit
// signed fields packed in tdata, pitch_cv in the lowest bits.
// The master channel m_axis returns one item per tick with the triangle,
// square and saw levels, 14 bits signed each.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_data_i; the
// user must do so only while the block is idle, which is not enforced.
// Each item runs through a sequencer of fourteen states: depth products,
// exponent, table lookup and interpolation, step scaling, phase update and
// waveform shaping. One item is in work at a time. The result register is
// loaded in the output state once the earlier result has been taken, and
// the next item can be accepted in the cycle after that load, so the block
// takes no new item before it is through with the last one.
// The result register holds its item until m_axis_tready is seen; a new
// item is accepted while an earlier result is waiting, but it does not
// leave the last step before that result is taken.
// Reset clears the phase, the direction and the sync flag and loads the
// register defaults.
module fm_sync_multiwave_oscillator_unit
  import fmo_pkg::*;
#(
  parameter int PHASE_BITS = DEF_PHASE_BITS,
  parameter int EXP_TABLE_DEPTH = DEF_EXP_TABLE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pitch_cv, exp_fm_cv, exp_depth_cv, lin_fm_cv, lin_depth_cv, sync_level,
  // mix_phase_mod, tri_phase_mod, sqr_phase_mod, saw_phase_mod
  input  logic [151:0]          s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tri_level, sqr_level, saw_level
  output logic [47:0]           m_axis_tdata
);

  logic signed [14:0] pitch_offset_q;
  logic signed [15:0] exp_fm_amount_q, lin_fm_amount_q;
  logic soft_sync_q;
  logic [29:0] step_scale_q;
  logic signed [12:0] tri_off_q, sqr_off_q, saw_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_offset_q <= '0;
      exp_fm_amount_q <= '0;
      lin_fm_amount_q <= '0;
      soft_sync_q <= 1'b0;
      step_scale_q <= STEP_SCALE_RESET;
      tri_off_q <= '0;
      sqr_off_q <= '0;
      saw_off_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PITCH_OFFSET: pitch_offset_q <= cfg_data_i[14:0];
        REG_EXP_FM_AMOUNT: exp_fm_amount_q <= cfg_data_i[15:0];
        REG_LIN_FM_AMOUNT: lin_fm_amount_q <= cfg_data_i[15:0];
        REG_SOFT_SYNC: soft_sync_q <= cfg_data_i[0];
        REG_STEP_SCALE: step_scale_q <= cfg_data_i;
        REG_TRI_OFFSET: tri_off_q <= cfg_data_i[12:0];
        REG_SQR_OFFSET: sqr_off_q <= cfg_data_i[12:0];
        REG_SAW_OFFSET: saw_off_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  fmo_cmd_t cmd;
  logic out_load, in_fire, out_valid_q;
  logic signed [13:0] tri_w, sqr_w, saw_w;
  logic [41:0] out_data_q;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  fmo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_busy_i (out_valid_q && !m_axis_tready),
    .in_ready_o (s_axis_tready),
    .out_load_o (out_load),
    .cmd_o      (cmd)
  );

  fmo_datapath #(
    .PHASE_BITS      (PHASE_BITS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .in_data_i          (s_axis_tdata[149:0]),
    .pitch_offset_i     (pitch_offset_q),
    .exp_fm_amount_i    (exp_fm_amount_q),
    .lin_fm_amount_i    (lin_fm_amount_q),
    .soft_sync_i        (soft_sync_q),
    .phase_step_scale_i (step_scale_q),
    .tri_phase_offset_i (tri_off_q),
    .sqr_phase_offset_i (sqr_off_q),
    .saw_phase_offset_i (saw_off_q),
    .tri_level_o        (tri_w),
    .sqr_level_o        (sqr_w),
    .saw_level_o        (saw_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_data_q <= {saw_w, sqr_w, tri_w};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {6'd0, out_data_q};

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && !m_axis_tready))
    else $error("result overwritten while waiting");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("second item accepted during work");

  a_sqr_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[27:14] == 14'd5120 ||
                       m_axis_tdata[27:14] == 14'h2C00))
    else $error("square level out of set");

endmodule

[test/tb_fm_sync_multiwave_oscillator_unit.sv]
`timescale 1ns / 1ps
module tb_fm_sync_multiwave_oscillator_unit;
  import fmo_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [151:0]          s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [47:0]           m_axis_tdata;

  fm_sync_multiwave_oscillator_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  longint unsigned pow2_table [257];
  longint pitch_ofs, exp_amt, lin_amt, tri_ofs, sqr_ofs, saw_ofs;
  logic soft_mode;
  longint unsigned step_scale;
  logic [31:0] phase;
  logic backward, trig_high;

  logic [47:0] wave_queue [$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  function automatic longint unsigned int_sqrt(input longint unsigned n_in);
    longint unsigned n, r, b;
    n = n_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint floor_div(input longint n, input longint d);
    longint q;
    q = n / d;
    if (n % d != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic build_pow2_table();
    longint unsigned roots [21];
    longint unsigned x, v;
    roots[0] = 64'd1 << 31;
    for (int k = 1; k <= 20; k++) roots[k] = int_sqrt(roots[k-1] << 30);
    for (int i = 0; i <= 256; i++) begin
      x = (longint'(i) << 20) / 256;
      v = 64'd1 << 30;
      if (x[20]) begin
        v = 64'd1 << 31;
        x = 0;
      end
      for (int j = 19; j >= 0; j--)
        if (x[j]) v = (v * roots[20-j]) >> 30;
      pow2_table[i] = v;
    end
  endtask

  function automatic logic [13:0] level_at(input logic [31:0] ph, input int mode);
    longint lvl;
    if (mode == 0) begin
      if (ph < 32'h8000_0000) lvl = FULL_SCALE - longint'((64'(ph) * 10240) >> 31);
      else lvl = longint'((64'(ph - 32'h8000_0000) * 10240) >> 31) - FULL_SCALE;
    end else if (mode == 1) begin
      lvl = ph < 32'h8000_0000 ? FULL_SCALE : -FULL_SCALE;
    end else begin
      lvl = longint'((64'(ph) * 10240) >> 32) - FULL_SCALE;
    end
    return lvl[13:0];
  endfunction

  // Advances the oscillator by one sample and returns the packed wave levels.
  function automatic logic [47:0] next_waves(input logic [151:0] d);
    longint pcv, efm, ed, lfm, ld, sl, mixm, trim, sqrm, sawm;
    longint e, u, ip, f, p, idx, rem, diff, m, pw, ratio;
    longint unsigned mag;
    logic rise, neg;
    logic [31:0] tp, qp, sp;
    pcv = $signed(d[14:0]);
    efm = $signed(d[29:15]);
    ed = clip($signed(d[44:30]), -FULL_SCALE, FULL_SCALE);
    lfm = $signed(d[59:45]);
    ld = clip($signed(d[74:60]), -FULL_SCALE, FULL_SCALE);
    sl = $signed(d[89:75]);
    mixm = $signed(d[104:90]);
    trim = $signed(d[119:105]);
    sqrm = $signed(d[134:120]);
    sawm = $signed(d[149:135]);
    rise = 1'b0;
    if (trig_high) begin
      if (sl <= SYNC_LO) trig_high = 1'b0;
    end else if (sl >= SYNC_HI) begin
      trig_high = 1'b1;
      rise = 1'b1;
    end
    e = pcv + pitch_ofs + floor_div(efm * ed * exp_amt, 64'd5120 * 16384);
    e = clip(e, -EXP_LIMIT, EXP_LIMIT);
    u = e + EXP_LIMIT;
    ip = u / 1024 - 12;
    f = u % 1024;
    p = f * 256;
    idx = p >> 10;
    rem = p & 1023;
    diff = longint'(pow2_table[idx+1]) - longint'(pow2_table[idx]);
    m = longint'(pow2_table[idx]) + floor_div(diff * rem, 1024);
    pw = ip >= 0 ? m << ip : m >> (-ip);
    ratio = pw + floor_div(lfm * ld * lin_amt, 80);
    if (rise && soft_mode) backward = ~backward;
    neg = ratio < 0;
    mag = neg ? -ratio : ratio;
    mag = (mag >> 30) * step_scale + (((mag & 64'h3FFF_FFFF) * step_scale) >> 30);
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    if (neg != backward) phase = phase - mag[31:0];
    else phase = phase + mag[31:0];
    if (rise && !soft_mode) phase = '0;
    tp = phase + 32'((mixm + trim + tri_ofs) << 20) - 32'h4000_0000;
    qp = phase + 32'((mixm + sqrm + sqr_ofs) << 20);
    sp = phase + 32'((mixm + sawm + saw_ofs) << 20);
    return {6'b0, level_at(sp, 2), level_at(qp, 1), level_at(tp, 0)};
  endfunction

  always @(posedge clk_i) m_axis_tready <= $urandom_range(99) >= stall_pct;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else if (rst_ni)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_fm_sync_multiwave_oscillator_unit: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    logic [47:0] want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (wave_queue.size() == 0) begin
        $error("unexpected item %h", m_axis_tdata);
        errors++;
      end else begin
        want = wave_queue.pop_front();
        if (m_axis_tdata[13:0] !== want[13:0]) begin
          $error("tri_level expected %0d actual %0d",
                 $signed(want[13:0]), $signed(m_axis_tdata[13:0]));
          errors++;
        end
        if (m_axis_tdata[27:14] !== want[27:14]) begin
          $error("sqr_level expected %0d actual %0d",
                 $signed(want[27:14]), $signed(m_axis_tdata[27:14]));
          errors++;
        end
        if (m_axis_tdata[41:28] !== want[41:28]) begin
          $error("saw_level expected %0d actual %0d",
                 $signed(want[41:28]), $signed(m_axis_tdata[41:28]));
          errors++;
        end
      end
    end
  end

  task automatic send_tick(input logic [14:0] f [10]);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b0, f[9], f[8], f[7], f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
    do @(posedge clk_i); while (!s_axis_tready);
    wave_queue.push_back(next_waves(s_axis_tdata));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (wave_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_regs(input longint v [8]);
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CFG_IDX_W'(i);
      cfg_data_i <= CFG_DATA_W'(v[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    pitch_ofs = $signed(15'(v[REG_PITCH_OFFSET]));
    exp_amt = $signed(16'(v[REG_EXP_FM_AMOUNT]));
    lin_amt = $signed(16'(v[REG_LIN_FM_AMOUNT]));
    soft_mode = v[REG_SOFT_SYNC][0];
    step_scale = 64'(v[REG_STEP_SCALE][29:0]);
    tri_ofs = $signed(13'(v[REG_TRI_OFFSET]));
    sqr_ofs = $signed(13'(v[REG_SQR_OFFSET]));
    saw_ofs = $signed(13'(v[REG_SAW_OFFSET]));
  endtask

  function automatic logic [14:0] rand_cv();
    case ($urandom_range(5))
      0: return 15'($urandom);
      1: return 15'h3FFF;
      2: return 15'h4000;
      default: return 15'($signed($urandom_range(20480)) - 10240);
    endcase
  endfunction

  function automatic logic [14:0] rand_sync();
    case ($urandom_range(7))
      0: return 15'd204;
      1: return 15'd205;
      2: return 15'd2047;
      3: return 15'd2048;
      4: return 15'($urandom);
      5: return 15'd0;
      default: return 15'd3000;
    endcase
  endfunction

  task automatic random_regs(input logic soft_sel);
    longint v [8];
    v[0] = $urandom_range(16384) - 8192;
    v[1] = $urandom_range(32768) - 16384;
    v[2] = $urandom_range(32768) - 16384;
    v[3] = soft_sel;
    v[4] = $urandom_range(3) == 0 ? longint'($urandom) & 30'h3FFF_FFFF
                                  : $urandom_range(100_000_000);
    v[5] = $urandom_range(4096) - 2048;
    v[6] = $urandom_range(4096) - 2048;
    v[7] = $urandom_range(4096) - 2048;
    write_regs(v);
  endtask

  task automatic test_field_extremes();
    logic [14:0] f [10];
    longint hi [8] = '{8192, 16384, 16384, 1, 30'h3FFF_FFFF, 2048, 2048, 2048};
    longint lo [8] = '{-8192, -16384, -16384, 0, 0, -2048, -2048, -2048};
    write_regs(hi);
    for (int k = 0; k < 6; k++) begin
      foreach (f[i]) f[i] = k[0] ? 15'h4000 : 15'h3FFF;
      if (k >= 2) f[3] = ~f[3];
      if (k >= 4) f[0] = 15'h0000;
      send_tick(f);
    end
    write_regs(lo);
    for (int k = 0; k < 4; k++) begin
      foreach (f[i]) f[i] = k[0] ? 15'h4000 : 15'h3FFF;
      send_tick(f);
    end
  endtask

  task automatic test_thru_zero();
    logic [14:0] f [10];
    longint v [8] = '{-8192, 0, -16384, 0, 23409861, 0, 0, 0};
    write_regs(v);
    for (int k = 0; k < 5; k++) begin
      foreach (f[i]) f[i] = '0;
      f[3] = 15'(10240 - 4096 * k);
      f[4] = 15'd5120;
      send_tick(f);
    end
  endtask

  task automatic test_sync(input logic soft_sel);
    logic [14:0] f [10];
    logic [14:0] lv [8] = '{15'd0, 15'd2047, 15'd2048, 15'd3000, 15'd205,
                            15'd2048, 15'd204, 15'd2048};
    longint v [8] = '{1024, 0, 0, 0, 80_000_000, 0, 0, 0};
    v[3] = soft_sel;
    write_regs(v);
    foreach (lv[k]) begin
      foreach (f[i]) f[i] = '0;
      f[5] = lv[k];
      send_tick(f);
    end
  endtask

  task automatic test_random(input int count);
    logic [14:0] f [10];
    for (int n = 0; n < count; n++) begin
      if (n % 90 == 0) random_regs($urandom_range(1));
      foreach (f[i]) f[i] = rand_cv();
      f[5] = rand_sync();
      send_tick(f);
    end
  endtask

  initial begin
    longint dflt [8] = '{0, 0, 0, 0, 23409861, 0, 0, 0};
    build_pow2_table();
    phase = '0;
    backward = 1'b0;
    trig_high = 1'b0;
    wave_queue.delete();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_regs(dflt);
    test_field_extremes();
    test_thru_zero();
    test_sync(1'b0);
    test_sync(1'b1);
    idle_pct = 0; stall_pct = 0;
    test_random(270);
    idle_pct = 57; stall_pct = 0;
    test_random(270);
    idle_pct = 0; stall_pct = 57;
    test_random(270);
    idle_pct = 12; stall_pct = 12;
    test_random(270);
    drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_fm_sync_multiwave_oscillator_unit: clean");
    end else begin
      $display("tb_fm_sync_multiwave_oscillator_unit: errors");
    end
    $finish;
  end

endmodule
